[hw/rtl/brb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg: shared types and constants of the byte ring buffer
// Item structs, operation and status codes, and the command word that
// travels from the front part to the back part.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned MAX_RUN     = 64;
  localparam int unsigned PTR_W       = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned RUN_W       = 7;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENQ  = 3'd0,
    FUNC_DEQ  = 3'd1,
    FUNC_PEEK = 3'd2,
    FUNC_SKIP = 3'd3,
    FUNC_ADV  = 3'd4,
    FUNC_CLR  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_OK   = 2'd1,
    ST_REJ  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_NOTE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_RUN   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] data_in;
    logic [RUN_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              last;
    logic [1:0]        status;
    logic [CNT_W-1:0]  used_count;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  direct_write_room;
    logic [CNT_W-1:0]  direct_read_room;
  } out_item_t;

  // One unit of work for the back part, with the fill state after the word.
  typedef struct packed {
    cmd_e              kind;
    status_e           status;
    logic [DATA_W-1:0] data;
    logic [PTR_W-1:0]  addr;
    logic [RUN_W-1:0]  len;
    logic [CNT_W-1:0]  used;
    logic [PTR_W-1:0]  wp;
    logic [PTR_W-1:0]  rp;
  } cmd_t;

endpackage

[hw/rtl/brb_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_front: accept and classify operations
// Holds the pointers and fill count, checks sizes, and pushes one command
// per accepted word of a known operation into the command queue.
// ----------------------------------------------------------------------------
module brb_front import brb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     init_done_i,
  input  logic     push_ready_i,
  output logic     push_valid_o,
  output cmd_t     push_cmd_o
);

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

  logic [CNT_W-1:0] used_q, used_d;
  logic [PTR_W-1:0] rp_q, rp_d;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] free;
  logic             known;
  logic             fire;
  cmd_t             cmd;

  assign in_ready_o = init_done_i && push_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign cnt        = CNT_W'(in_data_i.count);
  assign free       = CNT_W'(DEPTH) - used_q;

  always_comb begin
    used_d     = used_q;
    rp_d       = rp_q;
    wp_d       = wp_q;
    known      = 1'b1;
    cmd.kind   = CMD_NOTE;
    cmd.status = ST_OK;
    cmd.data   = in_data_i.data_in;
    cmd.addr   = wp_q;
    cmd.len    = in_data_i.count;
    unique case (func_e'(in_data_i.func))
      FUNC_ENQ: begin
        if (used_q == CNT_W'(DEPTH)) begin
          cmd.status = ST_REJ;
        end else begin
          cmd.kind = CMD_WRITE;
          wp_d     = ptr_add(wp_q, CNT_W'(1));
          used_d   = used_q + CNT_W'(1);
        end
      end
      FUNC_DEQ, FUNC_PEEK: begin
        cmd.addr = rp_q;
        if (cnt > used_q || cnt > CNT_W'(MAX_RUN)) begin
          cmd.status = ST_REJ;
        end else if (cnt != '0) begin
          cmd.kind = CMD_RUN;
          if (func_e'(in_data_i.func) == FUNC_DEQ) begin
            rp_d   = ptr_add(rp_q, cnt);
            used_d = used_q - cnt;
          end
        end
      end
      FUNC_SKIP: begin
        if (cnt > used_q) begin
          cmd.status = ST_REJ;
        end else begin
          rp_d   = ptr_add(rp_q, cnt);
          used_d = used_q - cnt;
        end
      end
      FUNC_ADV: begin
        if (cnt > free) begin
          cmd.status = ST_REJ;
        end else begin
          wp_d   = ptr_add(wp_q, cnt);
          used_d = used_q + cnt;
        end
      end
      FUNC_CLR: begin
        rp_d   = '0;
        wp_d   = '0;
        used_d = '0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    cmd.used = used_d;
    cmd.wp   = wp_d;
    cmd.rp   = rp_d;
  end

  assign push_valid_o = fire && known;
  assign push_cmd_o   = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      rp_q   <= '0;
      wp_q   <= '0;
    end else if (fire) begin
      used_q <= used_d;
      rp_q   <= rp_d;
      wp_q   <= wp_d;
    end
  end

endmodule

[hw/rtl/brb_cmd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_cmd_queue: short command queue
// Small first-in first-out store that decouples the front and back parts.
// ----------------------------------------------------------------------------
module brb_cmd_queue import brb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   fill_q;
  logic              push, pop;

  assign push_ready_o = fill_q != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign pop_cmd_o    = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

[hw/rtl/brb_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_back: execute commands against the byte store
// Owns the byte memory and its clearing sweep, walks runs one byte per
// cycle while the result buffer has room, and buffers results ahead of the
// output handshake.
module brb_back import brb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      pop_valid_i,
  output logic      pop_ready_o,
  input  cmd_t      pop_cmd_i,
  output logic      init_done_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [PTR_W-1:0]  sweep_q;
  logic              init_done_q;

  cmd_t              cur_q;
  logic              cur_valid_q;
  logic [RUN_W-1:0]  rem_q;
  logic [PTR_W-1:0]  addr_q;

  logic              infl_q;
  logic              is_data_q;
  out_item_t         meta_q, meta_d;

  out_item_t         obuf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head_q, tail_q;
  logic [QPTR_W:0]   ocnt_q;

  logic              space_ok, issue, finishing, load;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [CNT_W-1:0]  free, wroom, rroom;
  out_item_t         push_item;
  logic              opop;

  assign space_ok    = ((QPTR_W+1)'(ocnt_q) + (QPTR_W+1)'(infl_q))
                       < (QPTR_W+1)'(QUEUE_DEPTH);
  assign issue       = init_done_q && cur_valid_q && space_ok;
  assign finishing   = (cur_q.kind != CMD_RUN) || (rem_q == RUN_W'(1));
  assign pop_ready_o = init_done_q && (!cur_valid_q || (issue && finishing));
  assign load        = pop_valid_i && pop_ready_o;
  assign init_done_o = init_done_q;

  // Sweep zeros through the store after reset, then take command writes.
  assign mem_we    = !init_done_q || (issue && cur_q.kind == CMD_WRITE);
  assign mem_waddr = init_done_q ? addr_q : sweep_q;
  assign mem_wdata = init_done_q ? cur_q.data : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= '0;
      init_done_q <= 1'b0;
    end else if (!init_done_q) begin
      sweep_q <= sweep_q + PTR_W'(1);
      if (sweep_q == PTR_W'(DEPTH - 1)) begin
        init_done_q <= 1'b1;
      end
    end
  end

  // Current command and run walker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
    end else if (issue && finishing) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= pop_cmd_i;
      rem_q  <= pop_cmd_i.len;
      addr_q <= pop_cmd_i.addr;
    end else if (issue) begin
      rem_q  <= rem_q - RUN_W'(1);
      addr_q <= (addr_q == PTR_W'(DEPTH - 1)) ? '0 : addr_q + PTR_W'(1);
    end
  end

  // Fill state reported with every result of this command.
  always_comb begin
    free  = CNT_W'(DEPTH) - cur_q.used;
    wroom = CNT_W'(DEPTH) - CNT_W'(cur_q.wp);
    rroom = CNT_W'(DEPTH) - CNT_W'(cur_q.rp);
    meta_d.data_out          = '0;
    meta_d.last              = finishing;
    meta_d.status            = (cur_q.kind == CMD_RUN) ? ST_DATA : cur_q.status;
    meta_d.used_count        = cur_q.used;
    meta_d.free_count        = free;
    meta_d.direct_write_room = (free < wroom) ? free : wroom;
    meta_d.direct_read_room  = (cur_q.used < rroom) ? cur_q.used : rroom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= 1'b0;
    end else begin
      infl_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      meta_q    <= meta_d;
      is_data_q <= cur_q.kind == CMD_RUN;
    end
  end

  // Read data lands in the cycle after issue; merge it with the metadata.
  always_comb begin
    push_item          = meta_q;
    push_item.data_out = is_data_q ? rdata_q : '0;
  end

  assign out_valid_o = ocnt_q != '0;
  assign out_data_o  = obuf_q[head_q];
  assign opop        = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (infl_q) begin
      obuf_q[tail_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      ocnt_q <= '0;
    end else begin
      if (infl_q) begin
        tail_q <= (tail_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + QPTR_W'(1);
      end
      if (opop) begin
        head_q <= (head_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + QPTR_W'(1);
      end
      if (infl_q && !opop) begin
        ocnt_q <= ocnt_q + (QPTR_W+1)'(1);
      end else if (opop && !infl_q) begin
        ocnt_q <= ocnt_q - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

[hw/rtl/byte_ring_buffer.sv]
`timescale 1ns / 1ps
// Path: a result passes the command queue, the current command register, the
// read and metadata registers and the result buffer before it is offered.
// Throughput: front, one word per cycle while the 4-entry command queue has
// room; back, one result per cycle while its result buffer has room, through
// the single read port of the byte store. Reset: asynchronous, active low;
// a clearing pass then zeros all 1024 entries, accepting no word meanwhile.
// ----------------------------------------------------------------------------
// byte_ring_buffer: fixed-capacity circular byte FIFO
// Front part classifies and sizes operations, a command queue decouples it
// from the back part that reads and writes the byte store and emits results.
// ----------------------------------------------------------------------------
module byte_ring_buffer import brb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  logic init_done;
  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  // Front: hold pointers, reject requests that do not fit, emit one command per known word.
  brb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .init_done_i  (init_done),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  // Queue: let the front keep accepting while a long run drains.
  brb_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Back: apply writes, walk runs, buffer results for the output side.
  brb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .init_done_o (init_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // No word enters while the store is still being cleared.
  a_no_accept_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !in_ready_o)
    else $error("word accepted during clearing pass");

  // A rejected or data-less result always closes its word.
  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_DATA) |-> out_data_o.last)
    else $error("non-data result not marked last");

  // Only data results carry a byte.
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_DATA) |-> (out_data_o.data_out == '0))
    else $error("non-data result carries a byte");

  // Used and free always add up to the capacity.
  a_fill_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((CNT_W+1)'(out_data_o.used_count)
                     + (CNT_W+1)'(out_data_o.free_count) == (CNT_W+1)'(DEPTH)))
    else $error("used and free counts disagree");

endmodule
